@@ rtl/hht_pkg.sv @@
// Shared constants and a helper function for the Householder triangularization unit.
package hht_pkg;

    localparam int MAT_N  = 3;
    localparam int CELLS  = MAT_N * MAT_N;
    localparam int IDX_W  = (MAT_N > 1) ? $clog2(MAT_N) : 1;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ELEM_W = 32;
    localparam int THR_W  = 16;
    localparam int PADDR_W = 2;

    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(MAT_N - 1);

    function automatic logic [ELEM_W-1:0] mag32(input logic [ELEM_W-1:0] v);
        mag32 = v[ELEM_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

@@ rtl/hht_mem.sv @@
// Matrix store: one write port and one registered read port.
module hht_mem (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [hht_pkg::ADDR_W-1:0]    waddr,
    input  logic [hht_pkg::ELEM_W-1:0]    wdata,
    input  logic [hht_pkg::ADDR_W-1:0]    raddr,
    output logic [hht_pkg::ELEM_W-1:0]    rdata
);

    logic [hht_pkg::ELEM_W-1:0] mem [hht_pkg::CELLS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/hht_sqrt.sv @@
// Iterative 64-bit integer square root, two radicand bits per cycle.
module hht_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] x_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                x_reg    <= radicand;
                res_reg  <= '0;
                bit_reg  <= 64'd1 << 62;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (x_reg >= trial) begin
                    x_reg   <= x_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg == 64'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

@@ rtl/hht_div.sv @@
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module hht_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [63:0] num_reg;
    logic [63:0] q_reg;
    logic [31:0] rem_reg;
    logic [31:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    logic        ge;

    assign rem_sh  = {rem_reg, num_reg[63]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                num_reg  <= dividend;
                den_reg  <= divisor;
                rem_reg  <= '0;
                q_reg    <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= ge ? rem_sub[31:0] : rem_sh[31:0];
                q_reg   <= {q_reg[62:0], ge};
                num_reg <= {num_reg[62:0], 1'b0};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg[31:0];

endmodule

@@ rtl/householder_triangularize_unit.sv @@
// Top level: loads a matrix, triangularizes it with Householder reflections, streams it out.
// Loading accepts one input transaction per cycle while in the load state; each output entry is
// read, captured and held until accepted. After the last input, step k works on r = N-k rows
// with up to 27 scaling shifts, paced by the shared divider (one division per row), the two
// square roots and the single memory read port.
// Reset is synchronous and active low; the matrix store holds no reset value.
module householder_triangularize_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [31:0]                  s_tdata,   // [31:0] element
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,   // [31:0] r_element
    output logic                         m_tlast,
    output logic                         m_tuser,   // [0] degenerate
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hht_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    typedef enum logic [4:0] {
        S_LOAD, S_CRD, S_CCAP, S_SCL, S_SQ, S_SQA, S_SQRT_GO, S_SQRT_WAIT, S_UK,
        S_DIV_GO, S_DIV_WAIT, S_DRD, S_DMUL, S_DACC, S_URD, S_UMUL, S_UWR,
        S_TRD, S_TWR, S_ORD, S_OCAP, S_OWAIT
    } state_t;

    localparam logic signed [63:0] DOT_LIM = 64'sd8589934591;

    state_t                      state_reg;
    logic [hht_pkg::IDX_W-1:0]   k_reg, i_reg, j_reg;
    logic [hht_pkg::ADDR_W-1:0]  c_reg, load_cnt_reg;
    logic                        deg_reg, phase_reg;
    logic [hht_pkg::THR_W-1:0]   thr_reg;
    logic [31:0]                 m_reg  [hht_pkg::MAT_N];
    logic                        neg_reg[hht_pkg::MAT_N];
    logic [31:0]                 uh_reg [hht_pkg::MAT_N];
    logic signed [63:0]          acc_reg;
    logic [31:0]                 n_reg, s_reg;
    logic signed [34:0]          d_reg;
    logic [31:0]                 a_reg;
    logic [65:0]                 prod_reg;
    logic                        psign_reg;
    logic [31:0]                 out_data_reg;
    logic                        out_last_reg, out_deg_reg, out_valid_reg;

    logic                        mem_we;
    logic [hht_pkg::ADDR_W-1:0]  mem_waddr, mem_raddr, addr_ik, addr_ij;
    logic [31:0]                 mem_wdata, rdata;
    logic [33:0]                 mul_a;
    logic [31:0]                 mul_b;
    logic                        mul_sign;
    logic [65:0]                 rnd_sum;
    logic [35:0]                 rnd;
    logic [31:0]                 big;
    logic [31:0]                 uh_mag;
    logic [32:0]                 d_mag;
    logic signed [63:0]          dot_next;
    logic signed [37:0]          r_signed, a_new;
    logic [31:0]                 a_sat;
    logic signed [33:0]          uk_val;
    logic [31:0]                 uk_mag;
    logic                        sqrt_start, sqrt_done, div_start, div_done;
    logic [31:0]                 sqrt_root, div_q;
    logic [63:0]                 div_num;
    logic                        in_acc, out_acc;

    assign addr_ik = hht_pkg::ADDR_W'(i_reg) * hht_pkg::ADDR_W'(hht_pkg::MAT_N)
                     + hht_pkg::ADDR_W'(k_reg);
    assign addr_ij = hht_pkg::ADDR_W'(i_reg) * hht_pkg::ADDR_W'(hht_pkg::MAT_N)
                     + hht_pkg::ADDR_W'(j_reg);

    assign s_tready = (state_reg == S_LOAD);
    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = out_valid_reg && m_tready;

    assign uh_mag  = hht_pkg::mag32(uh_reg[i_reg]);
    assign d_mag   = d_reg[34] ? 33'(-d_reg) : 33'(d_reg);
    assign rnd_sum = prod_reg + 66'(64'd1 << 29);
    assign rnd     = rnd_sum[65:30];

    always_comb begin
        big = '0;
        for (int l = 0; l < hht_pkg::MAT_N; l++) begin
            if (hht_pkg::IDX_W'(l) >= k_reg && m_reg[l] > big) begin
                big = m_reg[l];
            end
        end
    end

    always_comb begin
        mul_a    = {2'b00, m_reg[i_reg]};
        mul_b    = m_reg[i_reg];
        mul_sign = 1'b0;
        case (state_reg)
            S_DMUL: begin
                mul_a    = {2'b00, uh_mag};
                mul_b    = hht_pkg::mag32(rdata);
                mul_sign = uh_reg[i_reg][31] ^ rdata[31];
            end
            S_UMUL: begin
                mul_a    = {1'b0, d_mag};
                mul_b    = uh_mag;
                mul_sign = d_reg[34] ^ uh_reg[i_reg][31];
            end
            default: begin
            end
        endcase
    end

    assign dot_next = acc_reg + (psign_reg ? -64'(rnd) : 64'(rnd));
    assign r_signed = psign_reg ? -38'(rnd) : 38'(rnd);
    assign a_new    = 38'(signed'(a_reg)) - (r_signed <<< 1);
    assign a_sat    = (a_new > 38'sd2147483647)  ? 32'h7FFF_FFFF :
                      (a_new < -38'sd2147483648) ? 32'h8000_0000 : a_new[31:0];

    assign uk_val = (neg_reg[k_reg] ? -34'(m_reg[k_reg]) : 34'(m_reg[k_reg]))
                    + 34'(n_reg);
    assign uk_mag = uk_val[33] ? 32'(-uk_val) : uk_val[31:0];

    assign div_num = {2'b00, m_reg[i_reg], 30'b0} + 64'(s_reg >> 1);

    assign sqrt_start = (state_reg == S_SQRT_GO);
    assign div_start  = (state_reg == S_DIV_GO);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = load_cnt_reg;
        mem_wdata = s_tdata;
        mem_raddr = c_reg;
        case (state_reg)
            S_LOAD: mem_we = in_acc;
            S_CRD:  mem_raddr = addr_ik;
            S_DRD, S_URD: mem_raddr = addr_ij;
            S_UWR: begin
                mem_we    = 1'b1;
                mem_waddr = addr_ij;
                mem_wdata = a_sat;
            end
            S_TWR: begin
                mem_we    = 1'b1;
                mem_waddr = c_reg;
                mem_wdata = (hht_pkg::mag32(rdata) < {16'b0, thr_reg}) ? '0 : rdata;
            end
            default: begin
            end
        endcase
    end

    hht_mem u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rdata)
    );

    hht_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (acc_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    hht_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (s_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        prod_reg  <= mul_a * mul_b;
        psign_reg <= mul_sign;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            load_cnt_reg  <= '0;
            deg_reg       <= 1'b0;
            thr_reg       <= '0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            c_reg         <= '0;
            phase_reg     <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                thr_reg <= pwdata[hht_pkg::THR_W-1:0];
            end
            case (state_reg)
                S_LOAD: begin
                    if (in_acc) begin
                        if (load_cnt_reg == hht_pkg::LAST_CELL) begin
                            k_reg     <= '0;
                            i_reg     <= '0;
                            state_reg <= S_CRD;
                        end else begin
                            load_cnt_reg <= load_cnt_reg + 1'b1;
                        end
                    end
                end
                S_CRD: state_reg <= S_CCAP;
                S_CCAP: begin
                    m_reg[i_reg]   <= hht_pkg::mag32(rdata);
                    neg_reg[i_reg] <= rdata[31];
                    if (i_reg == hht_pkg::LAST_IDX) begin
                        state_reg <= S_SCL;
                    end else begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_CRD;
                    end
                end
                S_SCL: begin
                    if (big == '0) begin
                        deg_reg   <= 1'b1;
                        c_reg     <= '0;
                        state_reg <= S_TRD;
                    end else if (big >= 32'h1000_0000) begin
                        for (int l = 0; l < hht_pkg::MAT_N; l++) m_reg[l] <= m_reg[l] >> 1;
                    end else if (big < 32'h0800_0000) begin
                        for (int l = 0; l < hht_pkg::MAT_N; l++) m_reg[l] <= m_reg[l] << 1;
                    end else begin
                        i_reg     <= k_reg;
                        acc_reg   <= '0;
                        phase_reg <= 1'b0;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ: state_reg <= S_SQA;
                S_SQA: begin
                    acc_reg <= acc_reg + signed'(prod_reg[63:0]);
                    if (i_reg == hht_pkg::LAST_IDX) begin
                        state_reg <= S_SQRT_GO;
                    end else begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_SQ;
                    end
                end
                S_SQRT_GO: state_reg <= S_SQRT_WAIT;
                S_SQRT_WAIT: begin
                    if (sqrt_done) begin
                        if (!phase_reg) begin
                            n_reg     <= sqrt_root;
                            state_reg <= S_UK;
                        end else if (sqrt_root == '0) begin
                            deg_reg   <= 1'b1;
                            c_reg     <= '0;
                            state_reg <= S_TRD;
                        end else begin
                            s_reg     <= sqrt_root;
                            i_reg     <= k_reg;
                            state_reg <= S_DIV_GO;
                        end
                    end
                end
                S_UK: begin
                    m_reg[k_reg]   <= uk_mag;
                    neg_reg[k_reg] <= uk_val[33];
                    for (int l = 0; l < hht_pkg::MAT_N; l++) begin
                        if (hht_pkg::IDX_W'(l) < k_reg) uh_reg[l] <= '0;
                    end
                    phase_reg <= 1'b1;
                    i_reg     <= k_reg;
                    acc_reg   <= '0;
                    state_reg <= S_SQ;
                end
                S_DIV_GO: state_reg <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (div_done) begin
                        uh_reg[i_reg] <= neg_reg[i_reg] ? -div_q : div_q;
                        if (i_reg == hht_pkg::LAST_IDX) begin
                            i_reg     <= k_reg;
                            j_reg     <= '0;
                            acc_reg   <= '0;
                            state_reg <= S_DRD;
                        end else begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_DIV_GO;
                        end
                    end
                end
                S_DRD:  state_reg <= S_DMUL;
                S_DMUL: state_reg <= S_DACC;
                S_DACC: begin
                    acc_reg <= dot_next;
                    if (i_reg == hht_pkg::LAST_IDX) begin
                        if (dot_next > DOT_LIM) begin
                            d_reg <= 35'(DOT_LIM);
                        end else if (dot_next < -DOT_LIM) begin
                            d_reg <= 35'(-DOT_LIM);
                        end else begin
                            d_reg <= dot_next[34:0];
                        end
                        i_reg     <= k_reg;
                        state_reg <= S_URD;
                    end else begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_DRD;
                    end
                end
                S_URD: state_reg <= S_UMUL;
                S_UMUL: begin
                    a_reg     <= rdata;
                    state_reg <= S_UWR;
                end
                S_UWR: begin
                    if (i_reg == hht_pkg::LAST_IDX) begin
                        i_reg <= k_reg;
                        if (j_reg == hht_pkg::LAST_IDX) begin
                            c_reg     <= '0;
                            state_reg <= S_TRD;
                        end else begin
                            j_reg     <= j_reg + 1'b1;
                            acc_reg   <= '0;
                            state_reg <= S_DRD;
                        end
                    end else begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_URD;
                    end
                end
                S_TRD: state_reg <= S_TWR;
                S_TWR: begin
                    if (c_reg == hht_pkg::LAST_CELL) begin
                        c_reg <= '0;
                        if (k_reg == hht_pkg::IDX_W'(hht_pkg::MAT_N - 2)) begin
                            state_reg <= S_ORD;
                        end else begin
                            k_reg     <= k_reg + 1'b1;
                            i_reg     <= k_reg + 1'b1;
                            state_reg <= S_CRD;
                        end
                    end else begin
                        c_reg     <= c_reg + 1'b1;
                        state_reg <= S_TRD;
                    end
                end
                S_ORD: state_reg <= S_OCAP;
                S_OCAP: begin
                    out_data_reg  <= rdata;
                    out_last_reg  <= (c_reg == hht_pkg::LAST_CELL);
                    out_deg_reg   <= deg_reg;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OWAIT;
                end
                S_OWAIT: begin
                    if (out_acc) begin
                        out_valid_reg <= 1'b0;
                        if (c_reg == hht_pkg::LAST_CELL) begin
                            load_cnt_reg <= '0;
                            deg_reg      <= 1'b0;
                            state_reg    <= S_LOAD;
                        end else begin
                            c_reg     <= c_reg + 1'b1;
                            state_reg <= S_ORD;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_deg_reg;
    assign prdata   = {16'b0, thr_reg};
    assign pready   = 1'b1;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

    a_back_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("unit did not return to loading after the last result");

    a_load_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && load_cnt_reg == hht_pkg::LAST_CELL) |=> !s_tready)
        else $error("unit kept loading past a full matrix");

endmodule

@@ sim/tb_householder_triangularize_unit.sv @@
// Self-checking testbench for the Householder triangularization unit.
`timescale 1ns / 100ps

module tb_householder_triangularize_unit;

    localparam logic [hht_pkg::PADDR_W-1:0] ADDR_ZERO_THRESHOLD = '0;

    typedef struct packed {
        logic [31:0] r_element;
        logic        is_last;
        logic        degenerate;
    } r_entry_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [31:0]         s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [31:0]         m_tdata;
    logic                m_tlast;
    logic                m_tuser;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [hht_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    logic [31:0] pending_elements[$];
    r_entry_t    expected_entries[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          mismatches = 0;

    // Shadow state of the block.
    longint      mat[hht_pkg::CELLS];
    longint      uhat[hht_pkg::MAT_N];
    int          loaded = 0;
    bit          skipped = 0;
    longint      threshold = 0;

    householder_triangularize_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit [63:0] magnitude(longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    function automatic longint with_sign(bit [63:0] m, bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic bit [63:0] int_sqrt(bit [63:0] x);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint q30_product(longint a, longint b);
        bit [63:0] p;
        p = magnitude(a) * magnitude(b);
        p = (p + (64'd1 << 29)) >> 30;
        return with_sign(p, (a < 0) != (b < 0));
    endfunction

    function automatic void reflect_column(int k);
        bit [63:0] m[hht_pkg::MAT_N];
        longint    u[hht_pkg::MAT_N];
        bit [63:0] big, sum, s, q;
        longint    d, a;
        big = 0;
        sum = 0;
        for (int i = k; i < hht_pkg::MAT_N; i++) begin
            m[i] = magnitude(mat[i*hht_pkg::MAT_N+k]);
            if (m[i] > big) big = m[i];
        end
        if (big == 0) begin
            skipped = 1;
            return;
        end
        while (big >= (64'd1 << 28)) begin
            big >>= 1;
            for (int i = k; i < hht_pkg::MAT_N; i++) m[i] >>= 1;
        end
        while (big < (64'd1 << 27)) begin
            big <<= 1;
            for (int i = k; i < hht_pkg::MAT_N; i++) m[i] <<= 1;
        end
        for (int i = k; i < hht_pkg::MAT_N; i++) begin
            u[i] = with_sign(m[i], mat[i*hht_pkg::MAT_N+k] < 0);
            sum += m[i] * m[i];
        end
        u[k] += longint'(int_sqrt(sum));
        sum = 0;
        for (int i = k; i < hht_pkg::MAT_N; i++) sum += magnitude(u[i]) * magnitude(u[i]);
        s = int_sqrt(sum);
        if (s == 0) begin
            skipped = 1;
            return;
        end
        for (int i = 0; i < hht_pkg::MAT_N; i++) begin
            if (i < k) begin
                uhat[i] = 0;
            end else begin
                q = ((magnitude(u[i]) << 30) + s / 2) / s;
                uhat[i] = with_sign(q, u[i] < 0);
            end
        end
        for (int j = 0; j < hht_pkg::MAT_N; j++) begin
            d = 0;
            for (int i = k; i < hht_pkg::MAT_N; i++)
                d += q30_product(uhat[i], mat[i*hht_pkg::MAT_N+j]);
            if (d > 64'sd8589934591) d = 64'sd8589934591;
            if (d < -64'sd8589934591) d = -64'sd8589934591;
            for (int i = k; i < hht_pkg::MAT_N; i++) begin
                a = mat[i*hht_pkg::MAT_N+j] - 2 * q30_product(uhat[i], d);
                if (a > 64'sd2147483647) a = 64'sd2147483647;
                if (a < -64'sd2147483648) a = -64'sd2147483648;
                mat[i*hht_pkg::MAT_N+j] = a;
            end
        end
    endfunction

    function automatic void load_element(logic [31:0] element);
        r_entry_t e;
        mat[loaded] = longint'(signed'(element));
        loaded++;
        if (loaded < hht_pkg::CELLS) return;
        for (int k = 0; k < hht_pkg::MAT_N - 1; k++) begin
            reflect_column(k);
            for (int c = 0; c < hht_pkg::CELLS; c++)
                if (magnitude(mat[c]) < 64'(threshold)) mat[c] = 0;
        end
        for (int c = 0; c < hht_pkg::CELLS; c++) begin
            e.r_element = mat[c][31:0];
            e.is_last = (c == hht_pkg::CELLS - 1);
            e.degenerate = skipped;
            expected_entries.push_back(e);
        end
        loaded = 0;
        skipped = 0;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) load_element(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (pending_elements.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_elements.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        r_entry_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_entries.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result transaction: data %h last %b degen %b",
                                 m_tdata, m_tlast, m_tuser);
                end else begin
                    want = expected_entries.pop_front();
                    if (m_tdata !== want.r_element || m_tlast !== want.is_last ||
                        m_tuser !== want.degenerate) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %h/%b/%b, got %h/%b/%b",
                                     want.r_element, want.is_last, want.degenerate,
                                     m_tdata, m_tlast, m_tuser);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_threshold(logic [15:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_ZERO_THRESHOLD;
        pwdata <= {16'($urandom_range(65535)), value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        threshold = value;
    endtask

    task automatic queue_random_matrix();
        int style;
        logic [31:0] x;
        style = $urandom_range(3);
        for (int c = 0; c < hht_pkg::CELLS; c++) begin
            case (style)
                0: x = $urandom;
                1: x = 32'(signed'($urandom_range(2097152)) - 1048576);
                2: begin
                    case ($urandom_range(3))
                        0: x = '0;
                        1: x = 32'h7fff_ffff;
                        2: x = 32'h8000_0000;
                        default: x = $urandom;
                    endcase
                end
                default: begin
                    // Leading column with only a pivot, often negative.
                    x = $urandom;
                    if (c % hht_pkg::MAT_N == 0 && c != 0) x = '0;
                end
            endcase
            pending_elements.push_back(x);
        end
    endtask

    task automatic drain();
        wait (pending_elements.size() == 0 && !s_tvalid && expected_entries.size() == 0);
        repeat (40) @(posedge aclk);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        write_threshold(16'd0);

        // Extremes of the element range.
        pending_elements.push_back(32'h7fff_ffff);
        pending_elements.push_back(32'h8000_0000);
        pending_elements.push_back(32'h7fff_ffff);
        pending_elements.push_back(32'h8000_0000);
        pending_elements.push_back(32'h7fff_ffff);
        pending_elements.push_back(32'h8000_0000);
        pending_elements.push_back(32'h7fff_ffff);
        pending_elements.push_back(32'h0000_0001);
        pending_elements.push_back(32'hffff_ffff);
        // Negative pivot with a zero column below it gives a zero reflector.
        for (int c = 0; c < hht_pkg::CELLS; c++)
            pending_elements.push_back(c == 0 ? 32'hfffe_0000 :
                                       (c % hht_pkg::MAT_N == 0) ? 32'h0 : 32'(c) << 16);
        // All-zero matrix skips every step.
        for (int c = 0; c < hht_pkg::CELLS; c++) pending_elements.push_back('0);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_threshold(16'hffff);
                1: write_threshold(16'(($urandom_range(255))));
                2: write_threshold(16'(($urandom)));
                default: write_threshold(16'd0);
            endcase
            send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 81 : 32) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 81 : 32) : 0;
            for (int n = 0; n < 4; n++) queue_random_matrix();
            drain();
        end

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/hht_pkg.sv
rtl/hht_mem.sv
rtl/hht_sqrt.sv
rtl/hht_div.sv
rtl/householder_triangularize_unit.sv
sim/tb_householder_triangularize_unit.sv
